// File: design/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, status codes and bracket tables for the bracket balance
// checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned PosWidth      = 16;
  localparam logic [PosWidth-1:0] PosMax = '1;
  localparam logic [7:0] SpaceSym = 8'h20;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_WRONG_CLOSER   = 3'd1,
    ST_MISSING_OPENER = 3'd2,
    ST_MISSING_CLOSER = 3'd3,
    ST_OVERFLOW       = 3'd4
  } status_e;

  // Operation applied to every stack cell together
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } stack_op_e;

  typedef logic [1:0] kind_t;

  typedef struct packed {
    status_e             status;
    logic [PosWidth-1:0] position;
    logic [7:0]          expected_symbol;
  } result_t;

  // Kind -> opener character
  function automatic logic [7:0] open_char(kind_t k);
    logic [7:0] c;
    unique case (k)
      2'd0:    c = 8'h28; // (
      2'd1:    c = 8'h7B; // {
      2'd2:    c = 8'h5B; // [
      default: c = 8'h3C; // <
    endcase
    return c;
  endfunction

  // Kind -> closer character
  function automatic logic [7:0] close_char(kind_t k);
    logic [7:0] c;
    unique case (k)
      2'd0:    c = 8'h29; // )
      2'd1:    c = 8'h7D; // }
      2'd2:    c = 8'h5D; // ]
      default: c = 8'h3E; // >
    endcase
    return c;
  endfunction

endpackage

// File: design/bracket_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks bracket balance of a character stream, one line at a time, with
// the bracket stack held in a shift chain of cells whose top is a register.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i / in_stall_o  symbol_i, line_end_i
// out      out  out_valid_o / out_stall_i status_o, position_o, expected_symbol_o
//
// One character is taken per clock unless stalled; an error or line-end result
// is registered into the output buffer. The stack top sits in cell 0, so push,
// pop and compare all finish in the accepting cycle. A two-entry output buffer
// (output register plus skid) lets input continue while a result waits; input
// stalls only when both entries are full. Reset clears the line state and the
// output buffer; stack cells are not cleared.
// ----------------------------------------------------------------------------
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          symbol_i,
  input  logic                line_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [PosWidth-1:0] position_o,
  output logic [7:0]          expected_symbol_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);

  logic                in_fire;
  logic [CntW-1:0]     count_q, count_d;
  logic [PosWidth-1:0] char_q, char_d, char_inc, pos_next;
  logic                skip_q, skip_d;
  stack_op_e           op;
  kind_t               kinds [STACK_DEPTH];
  kind_t               top, new_top;

  logic    is_open, is_close, push, pop, err, res_valid;
  kind_t   sym_kind;
  result_t res;

  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;
  assign top        = kinds[0];

  // Bracket decode
  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    sym_kind = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (symbol_i == open_char(kind_t'(k))) begin
        is_open  = 1'b1;
        sym_kind = kind_t'(k);
      end
      if (symbol_i == close_char(kind_t'(k))) begin
        is_close = 1'b1;
        sym_kind = kind_t'(k);
      end
    end
  end

  assign char_inc = (char_q == PosMax) ? PosMax : char_q + 1'b1;
  assign pos_next = (char_inc == PosMax) ? PosMax : char_inc + 1'b1;

  // Per-character check
  always_comb begin
    push      = 1'b0;
    pop       = 1'b0;
    err       = 1'b0;
    res_valid = 1'b0;
    res       = '{status: ST_OK, position: '0, expected_symbol: SpaceSym};
    new_top   = top;
    count_d   = count_q;
    char_d    = char_q;
    skip_d    = skip_q;
    if (in_fire) begin
      char_d = char_inc;
      if (!skip_q) begin
        if (is_open) begin
          if (count_q == CntFull) begin
            err        = 1'b1;
            res.status = ST_OVERFLOW;
          end else begin
            push    = 1'b1;
            new_top = sym_kind;
          end
        end else if (is_close) begin
          if (count_q == '0) begin
            err                 = 1'b1;
            res.status          = ST_MISSING_OPENER;
            res.expected_symbol = open_char(sym_kind);
          end else if (top == sym_kind) begin
            pop     = 1'b1;
            new_top = kinds[1];
          end else begin
            err                 = 1'b1;
            res.status          = ST_WRONG_CLOSER;
            res.expected_symbol = close_char(top);
          end
        end
        count_d = push ? count_q + 1'b1 : (pop ? count_q - 1'b1 : count_q);
        if (err) begin
          res.position = char_inc;
          res_valid    = 1'b1;
          skip_d       = 1'b1;
        end else if (line_end_i) begin
          res_valid = 1'b1;
          if (count_d != '0) begin
            res.status          = ST_MISSING_CLOSER;
            res.position        = pos_next;
            res.expected_symbol = close_char(new_top);
          end
        end
      end
      // line end starts a new line
      if (line_end_i) begin
        count_d = '0;
        char_d  = '0;
        skip_d  = 1'b0;
      end
    end
  end

  // Stack chain control
  always_comb begin
    priority if (push) begin
      op = OP_PUSH;
    end else if (pop) begin
      op = OP_POP;
    end else begin
      op = OP_HOLD;
    end
  end

  // Stack cells, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t up, down;
    if (i == 0) begin : g_top
      assign up = sym_kind;
    end else begin : g_up
      assign up = kinds[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down = kinds[i];
    end else begin : g_down
      assign down = kinds[i+1];
    end
    bbc_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .up_i   (up),
      .down_i (down),
      .kind_o (kinds[i])
    );
  end

  // Line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      char_q  <= '0;
      skip_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      char_q  <= char_d;
      skip_q  <= skip_d;
    end
  end

  // Output register plus skid
  assign out_fire = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign position_o        = out_q.position;
  assign expected_symbol_o = out_q.expected_symbol;

endmodule

// File: design/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell
// One stack entry. On push it takes the kind from the cell above (toward the
// top), on pop the kind from the cell below.
// ----------------------------------------------------------------------------
module bbc_cell
  import bbc_pkg::*;
(
  input  logic      clk_i,
  input  stack_op_e op_i,
  input  kind_t     up_i,
  input  kind_t     down_i,
  output kind_t     kind_o
);

  kind_t kind_q, kind_d;

  // shift selection
  always_comb begin
    unique case (op_i)
      OP_PUSH: kind_d = up_i;
      OP_POP:  kind_d = down_i;
      default: kind_d = kind_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule
